@@ sv/i2c_target_info_register_map_defines.svh @@
// Assertion helpers shared by the register map files.
`ifndef I2C_TARGET_INFO_REGISTER_MAP_DEFINES_SVH
`define I2C_TARGET_INFO_REGISTER_MAP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define I2CTIM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define I2CTIM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/i2ctim_pkg.sv @@
package i2ctim_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_TYPE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FW_VERSION   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HW_VERSION   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIP_ENABLED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_HIGH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_LAST  = 3'd6;

  // register pointer map
  localparam logic [7:0] IDX_CHIP_TEMP  = 8'd0;
  localparam logic [7:0] IDX_BOARD_TEMP = 8'd1;
  localparam logic [7:0] IDX_BOARD_TYPE = 8'd2;
  localparam logic [7:0] IDX_FW_VER     = 8'd3;
  localparam logic [7:0] IDX_HW_VER     = 8'd4;
  localparam logic [7:0] IDX_POWER_L    = 8'd5;
  localparam logic [7:0] IDX_POWER_H    = 8'd6;
  localparam logic [7:0] IDX_FW_VER_ALT = 8'd7;
  localparam logic [7:0] IDX_SN_FIRST   = 8'd8;
  localparam logic [7:0] IDX_SN_LAST    = 8'd24;

  localparam logic [7:0] BYTE_UNMAPPED  = 8'hFF;

  typedef enum logic [1:0] {
    FUNC_MATCH = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_TELEM = 2'd3
  } func_t;

  typedef logic [SLOT_IW-1:0] slot_idx_t;
  typedef logic [7:0][SLOT_IW-1:0] slot_tbl_t;

  // bus offset to slot index, folded modulo the slot count
  function automatic slot_tbl_t build_slot_tbl();
    slot_tbl_t t;
    for (int i = 0; i < 8; i++) begin
      t[i] = SLOT_IW'(i % SLOT_COUNT);
    end
    return t;
  endfunction

  localparam slot_tbl_t SLOT_MOD_TBL = build_slot_tbl();

  typedef struct packed {
    logic [7:0]  board_type;
    logic [7:0]  firmware_version;
    logic [7:0]  hardware_version;
    logic        chip_enabled;
    logic [63:0] serial_low;
    logic [63:0] serial_high;
    logic [7:0]  serial_last;
  } cfg_t;

  typedef struct packed {
    func_t      func;
    logic [2:0] bus_address_offset;
    logic       is_write;
    logic [7:0] data_byte;
    logic [2:0] slot;
    logic [7:0] chip_temp_value;
    logic [7:0] board_temp_value;
    logic [7:0] power_low_value;
    logic [7:0] power_high_value;
  } item_t;

endpackage

@@ sv/i2ctim_cfg.sv @@
module i2ctim_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [i2ctim_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [i2ctim_pkg::CFG_DATA_W-1:0]   wr_data,
  output i2ctim_pkg::cfg_t                    cfg
);
  import i2ctim_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_BOARD_TYPE:   cfg_r.board_type       <= wr_data[7:0];
        CFG_FW_VERSION:   cfg_r.firmware_version <= wr_data[7:0];
        CFG_HW_VERSION:   cfg_r.hardware_version <= wr_data[7:0];
        CFG_CHIP_ENABLED: cfg_r.chip_enabled     <= wr_data[0];
        CFG_SERIAL_LOW:   cfg_r.serial_low       <= wr_data;
        CFG_SERIAL_HIGH:  cfg_r.serial_high      <= wr_data;
        CFG_SERIAL_LAST:  cfg_r.serial_last      <= wr_data[7:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ sv/i2ctim_map.sv @@
`include "i2c_target_info_register_map_defines.svh"

module i2ctim_map (
  input  logic               clk,
  input  logic               rst_n,
  input  i2ctim_pkg::cfg_t   cfg,
  input  i2ctim_pkg::item_t  item,
  input  logic               item_go,
  output logic [7:0]         rd_byte
);
  import i2ctim_pkg::*;

  logic [7:0] ptr_r, ptr_nxt;
  logic       armed_r, armed_nxt;
  logic [2:0] matched_slot_r, matched_slot_nxt;
  logic [7:0] power_low_r, power_high_r;
  logic [7:0] chip_temps_r  [SLOT_COUNT];
  logic [7:0] board_temps_r [SLOT_COUNT];

  slot_idx_t    rd_slot;
  logic [135:0] sn_bytes;
  logic [4:0]   sn_idx;
  logic [7:0]   map_byte;
  logic         telem_slot_ok;

  assign rd_slot       = SLOT_MOD_TBL[matched_slot_r];
  assign sn_bytes      = {cfg.serial_last, cfg.serial_high, cfg.serial_low};
  assign sn_idx        = ptr_r[4:0] - 5'd8;
  assign telem_slot_ok = ({1'b0, item.slot} < 4'(SLOT_COUNT));

  always_comb begin
    case (ptr_r) inside
      IDX_CHIP_TEMP:              map_byte = chip_temps_r[rd_slot];
      IDX_BOARD_TEMP:             map_byte = board_temps_r[rd_slot];
      IDX_BOARD_TYPE:             map_byte = cfg.board_type;
      IDX_FW_VER, IDX_FW_VER_ALT: map_byte = cfg.firmware_version;
      IDX_HW_VER:                 map_byte = cfg.hardware_version;
      IDX_POWER_L:                map_byte = power_low_r;
      IDX_POWER_H:                map_byte = power_high_r;
      [IDX_SN_FIRST:IDX_SN_LAST]: map_byte = sn_bytes[{sn_idx, 3'b000} +: 8];
      default:                    map_byte = BYTE_UNMAPPED;
    endcase
  end

  // a disabled chip echoes the pointer
  assign rd_byte = cfg.chip_enabled ? map_byte : ptr_r;

  always_comb begin
    ptr_nxt          = ptr_r;
    armed_nxt        = armed_r;
    matched_slot_nxt = matched_slot_r;
    if (item_go) begin
      case (item.func)
        FUNC_MATCH: begin
          matched_slot_nxt = item.bus_address_offset;
          if (item.is_write) armed_nxt = 1'b1;
        end
        FUNC_WRITE: begin
          if (armed_r) begin
            ptr_nxt   = item.data_byte;
            armed_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + 8'd1;
          end
        end
        FUNC_READ: ptr_nxt = ptr_r + 8'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r          <= '0;
      armed_r        <= 1'b0;
      matched_slot_r <= '0;
      power_low_r    <= '0;
      power_high_r   <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        chip_temps_r[i]  <= '0;
        board_temps_r[i] <= '0;
      end
    end else begin
      ptr_r          <= ptr_nxt;
      armed_r        <= armed_nxt;
      matched_slot_r <= matched_slot_nxt;
      if (item_go && item.func == FUNC_TELEM) begin
        power_low_r  <= item.power_low_value;
        power_high_r <= item.power_high_value;
        if (telem_slot_ok) begin
          chip_temps_r[item.slot[SLOT_IW-1:0]]  <= item.chip_temp_value;
          board_temps_r[item.slot[SLOT_IW-1:0]] <= item.board_temp_value;
        end
      end
    end
  end

  `I2CTIM_ASSERT_NEXT(a_ptr_load, clk, rst_n,
    item_go && item.func == FUNC_WRITE && armed_r,
    ptr_r == $past(item.data_byte) && !armed_r)
  `I2CTIM_ASSERT_NEXT(a_read_advance, clk, rst_n,
    item_go && item.func == FUNC_READ,
    ptr_r == $past(ptr_r) + 8'd1)

endmodule

@@ sv/i2c_target_info_register_map.sv @@
// Channel | Handshake            | Payload
// in      | in_valid / in_stall  | func, bus_address_offset, is_write, data_byte, slot,
//         |                      | chip/board temps, power low/high bytes
// out     | out_valid / out_stall| read_data, one item per read event
// cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// One item per cycle unless in_stall: input register, map decode and pointer update,
// result register. A read result passes both registers; other events give none.
// Synchronous active-low reset clears the pointer, temperatures, power bytes and config.
// With the result register full and stalled, one more item is held in the input
// register; in_stall rises only when that item is a read that cannot move on.
`include "i2c_target_info_register_map_defines.svh"

module i2c_target_info_register_map (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_func,
  input  logic [2:0]                         in_bus_address_offset,
  input  logic                               in_is_write,
  input  logic [7:0]                         in_data_byte,
  input  logic [2:0]                         in_slot,
  input  logic [7:0]                         in_chip_temp_value,
  input  logic [7:0]                         in_board_temp_value,
  input  logic [7:0]                         in_power_low_value,
  input  logic [7:0]                         in_power_high_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_read_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [i2ctim_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2ctim_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import i2ctim_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  item_t s1_item_r;
  logic  s1_valid_r;
  logic  s1_is_read, s1_go, out_free;
  logic  out_valid_r;
  logic [7:0] out_data_r;
  logic [7:0] rd_byte;

  assign cfg_ready = 1'b1;

  i2ctim_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign in_item = '{
    func:               func_t'(in_func),
    bus_address_offset: in_bus_address_offset,
    is_write:           in_is_write,
    data_byte:          in_data_byte,
    slot:               in_slot,
    chip_temp_value:    in_chip_temp_value,
    board_temp_value:   in_board_temp_value,
    power_low_value:    in_power_low_value,
    power_high_value:   in_power_high_value
  };

  assign out_free   = !out_valid_r || !out_stall;
  assign s1_is_read = (s1_item_r.func == FUNC_READ);
  // non-read events retire without the result register
  assign s1_go      = s1_valid_r && (!s1_is_read || out_free);
  assign in_stall   = s1_valid_r && !s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) s1_item_r <= in_item;
  end

  i2ctim_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (s1_item_r),
    .item_go (s1_go),
    .rd_byte (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_is_read) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_is_read) out_data_r <= rd_byte;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  `I2CTIM_ASSERT_NOW(a_read_blocked, clk, rst_n,
    s1_valid_r && s1_is_read && out_valid_r && out_stall, in_stall && !s1_go)
  `I2CTIM_ASSERT_NEXT(a_read_lands, clk, rst_n,
    s1_go && s1_is_read, out_valid_r)
  `I2CTIM_ASSERT_NEXT(a_no_phantom, clk, rst_n,
    !(s1_go && s1_is_read) && !out_stall, !out_valid_r)

endmodule
